FILE: sv/hda_pkg.sv
// Shared types, constants and the sine-table helper for the harmonic
// distortion analyzer. No dependencies; imported by all modules but hda_isqrt.
package hda_pkg;

    localparam int DEF_SAMPLES   = 64;
    localparam int DEF_HARMONICS = 31;

    localparam int RATIO_SCALE = 6400;
    localparam int FUND_CODE   = 6399;
    localparam int RATIO_MAX   = 32767;
    localparam int SUM_SHIFT   = 7;

    localparam logic [15:0] VFLOOR_RST = 16'd0;
    localparam logic [15:0] CFLOOR_RST = 16'd8;

    // config register indexes
    localparam logic CFG_VFLOOR = 1'b0;
    localparam logic CFG_CFLOOR = 1'b1;

    localparam logic [2:0] CH_MAX_VALID = 3'd5;
    localparam logic [2:0] CH_FIRST_CUR = 3'd3;

    // shared multiplier operand width, divider widths
    localparam int MW     = 33;
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 32;

    // multiplier operations
    localparam logic [2:0] MUL_NONE = 3'd0;
    localparam logic [2:0] MUL_UA   = 3'd1;
    localparam logic [2:0] MUL_UB   = 3'd2;
    localparam logic [2:0] MUL_PP   = 3'd3;
    localparam logic [2:0] MUL_PS   = 3'd4;
    localparam logic [2:0] MUL_RS   = 3'd5;

    // result kinds
    localparam logic [1:0] OUT_SKIP  = 2'd0;
    localparam logic [1:0] OUT_FUND  = 2'd1;
    localparam logic [1:0] OUT_RATIO = 2'd2;

    // Q30 polynomial coefficients of the quarter-wave sine
    localparam logic [63:0] C1 = 64'd1686629713;
    localparam logic [63:0] C3 = 64'd693598669;
    localparam logic [63:0] C5 = 64'd85569306;
    localparam logic [63:0] C7 = 64'd5026995;
    localparam logic [63:0] C9 = 64'd172272;

    typedef struct packed {
        logic       run_init;
        logic       acc_clr;
        logic       issue;
        logic       next_h;
        logic [2:0] mul_op;
        logic       rad_ld;
        logic       rad_add;
        logic       sq_start;
        logic       tot;
        logic       div_start;
        logic       div_ratio;
        logic       set_fund;
        logic       sq_acc;
        logic       load_out;
        logic [1:0] out_sel;
        logic       final_res;
        logic [5:0] harm;
    } hda_cmd_t;

    typedef struct packed {
        logic last_fire;
        logic skip_now;
        logic issue_last;
        logic pipe_busy;
        logic sq_busy;
        logic div_busy;
        logic fund_zero;
        logic out_full;
    } hda_stat_t;

    // Q14 sine of a quarter-turn fraction xq (Q16); evaluated at elaboration
    function automatic logic [15:0] quarter_sine(input logic [63:0] xq);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        x2 = (xq * xq) >> 16;
        t  = C9;
        t  = C7 - ((t * x2) >> 16);
        t  = C5 - ((t * x2) >> 16);
        t  = C3 - ((t * x2) >> 16);
        t  = C1 - ((t * x2) >> 16);
        q  = (((t * xq) >> 16) + 64'd32768) >> 16;
        if (q > 64'd16384)
        begin
            q = 64'd16384;
        end
        return q[15:0];
    endfunction

endpackage

FILE: sv/hda_isqrt.sv
// Bit-pair serial integer square root of a 64-bit value, one step per cycle.
// Depends on hda_pkg only by convention; no package items used.
module hda_isqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] operand,
    output logic        busy,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] r_reg;
    logic [63:0] bit_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [63:0] trial;

    assign trial = r_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= operand;
            r_reg   <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_reg <= v_reg - trial;
                r_reg <= (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_reg <= r_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign busy = busy_reg;
    assign root = r_reg[31:0];

endmodule

FILE: sv/hda_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Widths come from hda_pkg.
module hda_div
    import hda_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              busy,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CNTW = $clog2(DIV_NW);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              busy_reg;
    logic [DIV_DW:0]   trial;
    logic              qbit;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign qbit  = (trial >= {1'b0, dvs_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNTW'(1);
            if (cnt_reg == CNTW'(DIV_NW - 1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (qbit)
            begin
                rem_reg <= DIV_DW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_reg <= trial[DIV_DW-1:0];
            end
            quo_reg <= {quo_reg[DIV_NW-2:0], qbit};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

FILE: sv/hda_ctrl.sv
// Sequencer for loading, per-harmonic DFT, root, divide and result issue.
// Uses hda_pkg command/status structs; drives the datapath and in_stall.
module hda_ctrl
    import hda_pkg::*;
#(
    parameter int HARMONICS = DEF_HARMONICS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  hda_stat_t stat,
    output hda_cmd_t  cmd,
    output logic      in_stall
);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_HSTART = 5'd1;
    localparam logic [4:0] S_ACC    = 5'd2;
    localparam logic [4:0] S_DRAIN  = 5'd3;
    localparam logic [4:0] S_SQA    = 5'd4;
    localparam logic [4:0] S_SQB    = 5'd5;
    localparam logic [4:0] S_SQC    = 5'd6;
    localparam logic [4:0] S_RGO    = 5'd7;
    localparam logic [4:0] S_RWAIT  = 5'd8;
    localparam logic [4:0] S_DGO    = 5'd9;
    localparam logic [4:0] S_DWAIT  = 5'd10;
    localparam logic [4:0] S_FCHK   = 5'd11;
    localparam logic [4:0] S_PP     = 5'd12;
    localparam logic [4:0] S_SQS    = 5'd13;
    localparam logic [4:0] S_TSC    = 5'd14;
    localparam logic [4:0] S_VGO    = 5'd15;
    localparam logic [4:0] S_VWAIT  = 5'd16;
    localparam logic [4:0] S_EMIT   = 5'd17;
    localparam logic [4:0] S_SKIP   = 5'd18;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic [5:0] h_reg;
    logic [5:0] h_next;
    logic       tot_reg;
    logic       tot_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        h_next     = h_reg;
        tot_next   = tot_reg;
        cmd.tot    = tot_reg;
        cmd.harm   = tot_reg ? 6'd0 : h_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (stat.last_fire)
                begin
                    h_next   = 6'd1;
                    tot_next = 1'b0;
                    if (stat.skip_now)
                    begin
                        state_next = S_SKIP;
                    end
                    else
                    begin
                        cmd.run_init = 1'b1;
                        state_next   = S_HSTART;
                    end
                end
            end
            S_HSTART:
            begin
                cmd.acc_clr = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.issue = 1'b1;
                if (stat.issue_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_SQA;
                end
            end
            S_SQA:
            begin
                cmd.mul_op = MUL_UA;
                state_next = S_SQB;
            end
            S_SQB:
            begin
                cmd.mul_op = MUL_UB;
                cmd.rad_ld = 1'b1;
                state_next = S_SQC;
            end
            S_SQC:
            begin
                cmd.rad_add = 1'b1;
                state_next  = S_RGO;
            end
            S_RGO:
            begin
                cmd.sq_start = 1'b1;
                state_next   = S_RWAIT;
            end
            S_RWAIT:
            begin
                if (!stat.sq_busy)
                begin
                    state_next = tot_reg ? S_TSC : S_DGO;
                end
            end
            S_DGO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = (h_reg == 6'd1) ? S_FCHK : S_PP;
                end
            end
            S_FCHK:
            begin
                cmd.set_fund = 1'b1;
                state_next   = stat.fund_zero ? S_SKIP : S_EMIT;
            end
            S_PP:
            begin
                cmd.mul_op = MUL_PP;
                state_next = S_SQS;
            end
            S_SQS:
            begin
                cmd.sq_acc = 1'b1;
                cmd.mul_op = MUL_PS;
                state_next = S_VGO;
            end
            S_TSC:
            begin
                cmd.mul_op = MUL_RS;
                state_next = S_VGO;
            end
            S_VGO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_ratio = 1'b1;
                state_next    = S_VWAIT;
            end
            S_VWAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (!stat.out_full)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.final_res = tot_reg;
                    cmd.out_sel   = (!tot_reg && h_reg == 6'd1) ? OUT_FUND : OUT_RATIO;
                    if (tot_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (h_reg == 6'(HARMONICS))
                    begin
                        tot_next   = 1'b1;
                        state_next = S_RGO;
                    end
                    else
                    begin
                        h_next     = h_reg + 6'd1;
                        cmd.next_h = 1'b1;
                        state_next = S_HSTART;
                    end
                end
            end
            S_SKIP:
            begin
                cmd.harm = 6'd0;
                if (!stat.out_full)
                begin
                    cmd.load_out  = 1'b1;
                    cmd.final_res = 1'b1;
                    cmd.out_sel   = OUT_SKIP;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            h_reg     <= 6'd1;
            tot_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg     <= h_next;
            tot_reg   <= tot_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

FILE: sv/hda_dp.sv
// Datapath: sample memory, sine table, DFT multiply-accumulate, shared
// multiplier, root and divider units, result register. Uses hda_pkg.
module hda_dp
    import hda_pkg::*;
#(
    parameter int SAMPLES = DEF_SAMPLES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [15:0] sample,
    input  logic [2:0]  channel,
    input  logic [15:0] level,
    input  logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  hda_cmd_t    cmd,
    output hda_stat_t   stat,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  out_channel,
    output logic [5:0]  harmonic,
    output logic [14:0] ratio,
    output logic        skipped,
    output logic        final_res
);

    localparam int AW   = $clog2(SAMPLES);
    localparam int CW   = $clog2(SAMPLES + 1);
    localparam int RW   = $clog2(4 * SAMPLES);
    localparam int ACCW = 33 + $clog2(SAMPLES);
    localparam int UAW  = ACCW - 1 - SUM_SHIFT;
    localparam logic [RW:0] S4 = (RW + 1)'(4 * SAMPLES);

    logic        in_fire;
    logic [15:0] vfloor_reg;
    logic [15:0] cfloor_reg;
    logic [CW-1:0] cnt_reg;
    logic [2:0]  chan_reg;
    logic [15:0] mem [SAMPLES];

    // sine table, built at elaboration
    logic signed [15:0] sin_rom [4 * SAMPLES];

    for (genvar k = 0; k < 4 * SAMPLES; k++)
    begin : g_rom
        localparam int QUAD = k / SAMPLES;
        localparam longint XQ = (longint'(k % SAMPLES) << 16) / SAMPLES;
        localparam logic [63:0] XS = (QUAD == 0 || QUAD == 2) ? 64'(XQ) : 64'd65536 - 64'(XQ);
        localparam logic [15:0] QV = quarter_sine(XS);
        assign sin_rom[k] = (QUAD >= 2) ? -$signed(QV) : $signed(QV);
    end

    assign in_fire = in_valid & ~in_stall;

    // config and load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vfloor_reg <= VFLOOR_RST;
            cfloor_reg <= CFLOOR_RST;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_VFLOOR)
                begin
                    vfloor_reg <= cfg_data;
                end
                else
                begin
                    cfloor_reg <= cfg_data;
                end
            end
            if (in_fire)
            begin
                if (last)
                begin
                    cnt_reg <= '0;
                end
                else if (cnt_reg < CW'(SAMPLES))
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && last)
        begin
            chan_reg <= channel;
        end
    end

    assign stat.last_fire = in_fire & last;
    assign stat.skip_now  = (channel > CH_MAX_VALID) ||
                            (level < ((channel < CH_FIRST_CUR) ? vfloor_reg : cfloor_reg));

    // DFT accumulation pipeline
    logic [CW-1:0] n_reg;
    logic [AW-1:0] ph_reg;
    logic [AW-1:0] hm_reg;
    logic [AW:0]   ph_sum;
    logic [AW-1:0] ph_next;
    logic [AW-1:0] rd_addr;
    logic [RW-1:0] sidx;
    logic [RW:0]   csum;
    logic [RW-1:0] cidx;
    logic [15:0]   rd_q_reg;
    logic [15:0]   prev_reg;
    logic signed [15:0] sin_q_reg;
    logic signed [15:0] cos_q_reg;
    logic          v1_reg;
    logic          f1_reg;
    logic          v2_reg;
    logic signed [16:0] diff;
    logic signed [32:0] prod_s_reg;
    logic signed [32:0] prod_c_reg;
    logic signed [ACCW-1:0] sa_reg;
    logic signed [ACCW-1:0] sb_reg;

    assign ph_sum  = {1'b0, ph_reg} + {1'b0, hm_reg};
    assign ph_next = (ph_sum >= (AW + 1)'(SAMPLES)) ? AW'(ph_sum - (AW + 1)'(SAMPLES))
                                                      : ph_sum[AW-1:0];
    assign rd_addr = (n_reg == CW'(SAMPLES)) ? '0 : n_reg[AW-1:0];
    assign sidx    = RW'(ph_reg) << 2;
    assign csum    = (RW + 1)'(sidx) + (RW + 1)'(SAMPLES);
    assign cidx    = (csum >= S4) ? RW'(csum - S4) : csum[RW-1:0];
    assign diff    = $signed({1'b0, rd_q_reg}) - $signed({1'b0, prev_reg});

    assign stat.issue_last = (n_reg == CW'(SAMPLES));
    assign stat.pipe_busy  = v1_reg | v2_reg;

    always_ff @(posedge clk)
    begin
        if (in_fire && cnt_reg < CW'(SAMPLES))
        begin
            mem[cnt_reg[AW-1:0]] <= sample;
        end
        if (cmd.issue)
        begin
            rd_q_reg  <= mem[rd_addr];
            sin_q_reg <= sin_rom[sidx];
            cos_q_reg <= sin_rom[cidx];
            f1_reg    <= (n_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg & ~f1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.run_init)
        begin
            hm_reg <= AW'(1);
        end
        else if (cmd.next_h)
        begin
            hm_reg <= (hm_reg == AW'(SAMPLES - 1)) ? '0 : hm_reg + AW'(1);
        end
        if (cmd.acc_clr)
        begin
            n_reg  <= '0;
            ph_reg <= '0;
            sa_reg <= '0;
            sb_reg <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                n_reg  <= n_reg + CW'(1);
                ph_reg <= ph_next;
            end
            if (v2_reg)
            begin
                sa_reg <= sa_reg - ACCW'(prod_s_reg);
                sb_reg <= sb_reg + ACCW'(prod_c_reg);
            end
        end
        if (v1_reg)
        begin
            prev_reg   <= rd_q_reg;
            prod_s_reg <= diff * sin_q_reg;
            prod_c_reg <= diff * cos_q_reg;
        end
    end

    // magnitude, roots and ratios
    logic [ACCW-1:0]   abs_a;
    logic [ACCW-1:0]   abs_b;
    logic [UAW-1:0]    ua;
    logic [UAW-1:0]    ub;
    logic [MW-1:0]     mul_a;
    logic [MW-1:0]     mul_b;
    logic [2*MW-1:0]   mul_q_reg;
    logic [63:0]       rad_reg;
    logic [63:0]       sqsum_reg;
    logic [64:0]       sqsum_add;
    logic [31:0]       fund_reg;
    logic              sq_busy;
    logic [31:0]       root;
    logic              div_busy;
    logic [DIV_NW-1:0] div_q;
    logic [DIV_NW-1:0] div_n;
    logic [DIV_DW-1:0] div_d;

    assign abs_a = (sa_reg < 0) ? ACCW'(-sa_reg) : ACCW'(sa_reg);
    assign abs_b = (sb_reg < 0) ? ACCW'(-sb_reg) : ACCW'(sb_reg);
    assign ua    = abs_a[ACCW-2:SUM_SHIFT];
    assign ub    = abs_b[ACCW-2:SUM_SHIFT];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            MUL_UA:
            begin
                mul_a = MW'(ua);
                mul_b = MW'(ua);
            end
            MUL_UB:
            begin
                mul_a = MW'(ub);
                mul_b = MW'(ub);
            end
            MUL_PP:
            begin
                mul_a = MW'(div_q[31:0]);
                mul_b = MW'(div_q[31:0]);
            end
            MUL_PS:
            begin
                mul_a = MW'(div_q[31:0]);
                mul_b = MW'(RATIO_SCALE);
            end
            MUL_RS:
            begin
                mul_a = MW'(root);
                mul_b = MW'(RATIO_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sqsum_add = {1'b0, sqsum_reg} + {1'b0, mul_q_reg[63:0]};

    always_ff @(posedge clk)
    begin
        if (cmd.mul_op != MUL_NONE)
        begin
            mul_q_reg <= mul_a * mul_b;
        end
        if (cmd.rad_ld)
        begin
            rad_reg <= mul_q_reg[63:0];
        end
        else if (cmd.rad_add)
        begin
            rad_reg <= rad_reg + mul_q_reg[63:0];
        end
        if (cmd.run_init)
        begin
            sqsum_reg <= '0;
        end
        else if (cmd.sq_acc)
        begin
            sqsum_reg <= sqsum_add[64] ? '1 : sqsum_add[63:0];
        end
        if (cmd.set_fund)
        begin
            fund_reg <= div_q[31:0];
        end
    end

    hda_isqrt u_isqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.sq_start),
        .operand (cmd.tot ? sqsum_reg : rad_reg),
        .busy    (sq_busy),
        .root    (root)
    );

    assign div_n = cmd.div_ratio ? mul_q_reg[DIV_NW-1:0] : DIV_NW'(root);
    assign div_d = cmd.div_ratio ? fund_reg : DIV_DW'(cmd.harm);

    hda_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .busy     (div_busy),
        .quotient (div_q)
    );

    assign stat.sq_busy   = sq_busy;
    assign stat.div_busy  = div_busy;
    assign stat.fund_zero = (div_q == '0);

    // result register
    logic        out_valid_reg;
    logic [2:0]  out_channel_reg;
    logic [5:0]  harmonic_reg;
    logic [14:0] ratio_reg;
    logic        skipped_reg;
    logic        final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_channel_reg <= chan_reg;
            harmonic_reg    <= cmd.harm;
            final_reg       <= cmd.final_res;
            skipped_reg     <= (cmd.out_sel == OUT_SKIP);
            unique case (cmd.out_sel)
                OUT_SKIP:  ratio_reg <= '0;
                OUT_FUND:  ratio_reg <= 15'(FUND_CODE);
                default:   ratio_reg <= (div_q > DIV_NW'(RATIO_MAX)) ? 15'(RATIO_MAX)
                                                                     : div_q[14:0];
            endcase
        end
    end

    assign stat.out_full = out_valid_reg;
    assign out_valid     = out_valid_reg;
    assign out_channel   = out_channel_reg;
    assign harmonic      = harmonic_reg;
    assign ratio         = ratio_reg;
    assign skipped       = skipped_reg;
    assign final_res     = final_reg;

    // a pending beat is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !out_valid_reg)
        else $error("result register overwritten");

    // samples only load while the accumulation pipeline, root and divider are idle
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> !(v1_reg || v2_reg || sq_busy || div_busy))
        else $error("sample accepted during analysis");

    // arithmetic units are never restarted mid-operation
    a_unit_start: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.sq_start |-> !sq_busy) and (cmd.div_start |-> !div_busy))
        else $error("unit restarted while busy");

    // the divider is started only after the root has settled
    a_div_after_root: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> div_busy && !sq_busy)
        else $error("divider start sequencing");

endmodule

FILE: sv/harmonic_distortion_analyzer_core.sv
// Harmonic distortion analyzer. Samples of one waveform cycle load one beat
// per cycle while in_stall is low; the beat flagged last closes the cycle and
// starts analysis. While analysis runs, in_stall is high. Each harmonic above
// the fundamental clears, runs and drains the one-tap-per-cycle DFT
// multiply-accumulate, squares the two sums and takes the bit-pair square root,
// then runs two bit-serial divides (one for the harmonic scaling, one for the
// ratio) and squares, scales and issues the result. The fundamental skips the
// ratio divide; the total distortion adds one more root and divide. Results
// leave through a registered output, so a final beat may wait on out_stall
// while the next cycle loads.
module harmonic_distortion_analyzer_core
    import hda_pkg::*;
#(
    parameter int SAMPLES   = DEF_SAMPLES,
    parameter int HARMONICS = DEF_HARMONICS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] sample,
    input  logic [2:0]  channel,
    input  logic [15:0] level,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  out_channel,
    output logic [5:0]  harmonic,
    output logic [14:0] ratio,
    output logic        skipped,
    output logic        final_res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    hda_cmd_t  cmd;
    hda_stat_t stat;

    hda_ctrl #(
        .HARMONICS (HARMONICS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    hda_dp #(
        .SAMPLES (SAMPLES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .channel     (channel),
        .level       (level),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_channel (out_channel),
        .harmonic    (harmonic),
        .ratio       (ratio),
        .skipped     (skipped),
        .final_res   (final_res)
    );

endmodule

FILE: test/tb_harmonic_distortion_analyzer_core.sv
// Testbench for harmonic_distortion_analyzer_core: drives waveform cycles,
// predicts per-harmonic ratios and total distortion, checks each result beat.
// Depends on hda_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_harmonic_distortion_analyzer_core;
    import hda_pkg::*;

    localparam int NS = DEF_SAMPLES;
    localparam int NH = DEF_HARMONICS;

    localparam int WAVE_NOISE  = 0;
    localparam int WAVE_SQUARE = 1;
    localparam int WAVE_FLAT   = 2;
    localparam int WAVE_TRI    = 3;

    typedef struct packed {
        logic [2:0]  chan;
        logic [5:0]  harm;
        logic [14:0] ratio;
        logic        skip;
        logic        fin;
    } result_t;

    typedef struct {
        int         wave;
        int         nsamp;
        logic [2:0] chan;
        logic [15:0] lvl;
        bit         typed_skip;
    } cycle_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [15:0] sample;
    logic [2:0]  channel;
    logic [15:0] level;
    logic        last;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  out_channel;
    logic [5:0]  harmonic;
    logic [14:0] ratio;
    logic        skipped;
    logic        final_res;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    // predictor state
    logic [15:0] readings [NS];
    int          reading_count;
    logic [15:0] vfloor_shadow;
    logic [15:0] cfloor_shadow;
    longint      sin_q14 [4*NS];
    result_t     pending_results [$];

    int          mismatches;
    int          results_seen;
    int          beats_sent;
    int          cycles_analyzed;
    int          skips_seen;
    int          burst_left;
    int          wave_amp;
    int          wave_off;
    int          wave_ripple;

    harmonic_distortion_analyzer_core dut (.*);

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // receiver stall: randomly chosen modes of free flow, light and heavy stalling
    int stall_mode;
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 300);
        end
        stall_left = stall_left - 1;
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic longint poly_sine(logic [63:0] xq);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] q;
        x2 = (xq * xq) >> 16;
        t = 64'd172272;
        t = 64'd5026995 - ((t * x2) >> 16);
        t = 64'd85569306 - ((t * x2) >> 16);
        t = 64'd693598669 - ((t * x2) >> 16);
        t = 64'd1686629713 - ((t * x2) >> 16);
        q = (((t * xq) >> 16) + 64'd32768) >> 16;
        if (q > 64'd16384)
        begin
            q = 64'd16384;
        end
        return longint'(q);
    endfunction

    function automatic logic [63:0] root64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [14:0] scaled(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        q = (num * 64'd6400) / den;
        return (q > RATIO_MAX) ? 15'(RATIO_MAX) : q[14:0];
    endfunction

    function automatic void push_result(logic [2:0] ch, logic [5:0] h, logic [14:0] r,
                                        logic sk, logic fn);
        result_t e;
        e.chan = ch;
        e.harm = h;
        e.ratio = r;
        e.skip = sk;
        e.fin = fn;
        pending_results.push_back(e);
    endfunction

    function automatic void store_reading(logic [15:0] s);
        if (reading_count < NS)
        begin
            readings[reading_count] = s;
            reading_count++;
        end
    endfunction

    function automatic void predict_spectrum(logic [2:0] ch, logic [15:0] lv);
        longint      sa;
        longint      sb;
        longint      d;
        logic [63:0] ua;
        logic [63:0] ub;
        logic [63:0] amp [NH+1];
        logic [63:0] ssum;
        logic [63:0] sq;
        logic [15:0] flr;
        int          ang;
        flr = (ch < 3) ? vfloor_shadow : cfloor_shadow;
        if (ch > 5 || lv < flr)
        begin
            push_result(ch, 0, 0, 1'b1, 1'b1);
            return;
        end
        ssum = 0;
        for (int h = 1; h <= NH; h++)
        begin
            sa = 0;
            sb = 0;
            for (int n = 1; n <= NS; n++)
            begin
                d = longint'(readings[n % NS]) - longint'(readings[n-1]);
                ang = (4 * n * h) % (4 * NS);
                sa = sa - d * sin_q14[ang];
                sb = sb + d * sin_q14[(ang + NS) % (4 * NS)];
            end
            ua = ((sa < 0) ? -sa : sa) >> SUM_SHIFT;
            ub = ((sb < 0) ? -sb : sb) >> SUM_SHIFT;
            amp[h] = root64(ua * ua + ub * ub) / h;
            if (h > 1)
            begin
                sq = amp[h] * amp[h];
                ssum = (ssum > ~sq) ? '1 : ssum + sq;
            end
        end
        if (amp[1] == 0)
        begin
            push_result(ch, 0, 0, 1'b1, 1'b1);
            return;
        end
        push_result(ch, 1, 15'(FUND_CODE), 1'b0, 1'b0);
        for (int h = 2; h <= NH; h++)
        begin
            push_result(ch, 6'(h), scaled(amp[h], amp[1]), 1'b0, 1'b0);
        end
        push_result(ch, 0, scaled(root64(ssum), amp[1]), 1'b0, 1'b1);
    endfunction

    function automatic logic [15:0] make_reading(int wave, int i);
        int v;
        int p;
        p = i % NS;
        case (wave)
            WAVE_NOISE:  v = $urandom_range(0, 65535);
            WAVE_SQUARE: v = (p < NS / 2) ? 65535 : 0;
            WAVE_FLAT:   v = wave_off;
            default:
            begin
                v = wave_off + (wave_amp * ((p < NS / 2) ? p : NS - 1 - p)) / 32
                    + $urandom_range(0, wave_ripple);
            end
        endcase
        if (v > 65535)
        begin
            v = 65535;
        end
        return 16'(v);
    endfunction

    // one input beat, with sender bursts and gaps; returns at the next falling edge
    task automatic send_beat(logic [15:0] s, logic [2:0] ch, logic [15:0] lv, logic lst);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        in_valid = 1'b1;
        sample = s;
        channel = ch;
        level = lv;
        last = lst;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        beats_sent++;
        store_reading(s);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic run_cycle(cycle_row_t row);
        logic [2:0]  ch;
        logic [15:0] lv;
        bit          lst;
        for (int i = 0; i < row.nsamp; i++)
        begin
            lst = (i == row.nsamp - 1);
            ch = lst ? row.chan : 3'($urandom_range(0, 7));
            lv = lst ? row.lvl : 16'($urandom_range(0, 65535));
            send_beat(make_reading(row.wave, i), ch, lv, lst);
        end
        if (row.typed_skip)
        begin
            push_result(row.chan, 0, 0, 1'b1, 1'b1);
        end
        else
        begin
            predict_spectrum(row.chan, row.lvl);
        end
        reading_count = 0;
        cycles_analyzed++;
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(negedge clk);
    endtask

    task automatic write_floor(logic idx, logic [15:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_VFLOOR)
        begin
            vfloor_shadow = val;
        end
        else
        begin
            cfloor_shadow = val;
        end
    endtask

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (skipped)
            begin
                skips_seen++;
            end
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result beat: ch=%0d h=%0d ratio=%0d skip=%0b fin=%0b",
                             out_channel, harmonic, ratio, skipped, final_res);
                end
            end
            else
            begin
                e = pending_results.pop_front();
                if (out_channel !== e.chan || harmonic !== e.harm || ratio !== e.ratio
                    || skipped !== e.skip || final_res !== e.fin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch: exp ch=%0d h=%0d ratio=%0d skip=%0b fin=%0b",
                                 e.chan, e.harm, e.ratio, e.skip, e.fin);
                        $display("          got ch=%0d h=%0d ratio=%0d skip=%0b fin=%0b",
                                 out_channel, harmonic, ratio, skipped, final_res);
                    end
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout waiting for results");
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        cycle_row_t dir [$];
        cycle_row_t row;
        int         rnd_beats;

        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        channel = '0;
        level = '0;
        last = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_VFLOOR;
        cfg_data = '0;
        burst_left = 0;
        reading_count = 0;
        mismatches = 0;
        results_seen = 0;
        beats_sent = 0;
        cycles_analyzed = 0;
        skips_seen = 0;
        vfloor_shadow = VFLOOR_RST;
        cfloor_shadow = CFLOOR_RST;
        wave_amp = 20000;
        wave_off = 1000;
        wave_ripple = 300;
        for (int k = 0; k < 4 * NS; k++)
        begin
            case (k / NS)
                0: sin_q14[k] = poly_sine(((k % NS) << 16) / NS);
                1: sin_q14[k] = poly_sine(65536 - ((k % NS) << 16) / NS);
                2: sin_q14[k] = -poly_sine(((k % NS) << 16) / NS);
                default: sin_q14[k] = -poly_sine(65536 - ((k % NS) << 16) / NS);
            endcase
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed cycles at reset floors (voltage 0, current 8)
        dir.push_back('{WAVE_TRI,    NS,     3'd0, 16'd0,     1'b0});
        dir.push_back('{WAVE_SQUARE, NS,     3'd3, 16'd8,     1'b0});
        dir.push_back('{WAVE_TRI,    4,      3'd3, 16'd7,     1'b1});
        dir.push_back('{WAVE_NOISE,  4,      3'd6, 16'd65535, 1'b1});
        dir.push_back('{WAVE_NOISE,  4,      3'd7, 16'd65535, 1'b1});
        dir.push_back('{WAVE_FLAT,   NS,     3'd1, 16'd100,   1'b1});
        dir.push_back('{WAVE_NOISE,  10,     3'd2, 16'd65535, 1'b0});
        dir.push_back('{WAVE_TRI,    NS + 4, 3'd4, 16'd500,   1'b0});
        dir.push_back('{WAVE_NOISE,  1,      3'd5, 16'd9,     1'b0});
        foreach (dir[i])
        begin
            run_cycle(dir[i]);
        end
        drain();

        // floors at opposite extremes
        write_floor(CFG_VFLOOR, 16'hFFFF);
        write_floor(CFG_CFLOOR, 16'h0000);
        dir.delete();
        dir.push_back('{WAVE_NOISE,  NS, 3'd0, 16'hFFFF, 1'b0});
        dir.push_back('{WAVE_TRI,    4,  3'd1, 16'hFFFE, 1'b1});
        dir.push_back('{WAVE_SQUARE, NS, 3'd5, 16'd0,    1'b0});
        foreach (dir[i])
        begin
            run_cycle(dir[i]);
        end

        // random: mostly full cycles, some short, long, dead-channel or low-level ones
        rnd_beats = 0;
        while (rnd_beats < 40)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                drain();
                write_floor(CFG_VFLOOR, 16'($urandom_range(0, 3) == 0 ?
                            $urandom_range(0, 65535) : $urandom_range(0, 2000)));
                write_floor(CFG_CFLOOR, 16'($urandom_range(0, 3) == 0 ?
                            $urandom_range(0, 65535) : $urandom_range(0, 2000)));
            end
            row.wave = $urandom_range(0, 3);
            row.chan = 3'($urandom_range(0, 5));
            row.lvl = 16'($urandom_range(0, 4) == 0 ? $urandom_range(0, 2000)
                                                    : $urandom_range(2000, 65535));
            row.nsamp = NS;
            row.typed_skip = 1'b0;
            wave_amp = $urandom_range(0, 65535);
            wave_off = $urandom_range(0, 65535 - wave_amp / 2);
            wave_ripple = $urandom_range(0, 2000);
            case ($urandom_range(0, 9))
                0: row.nsamp = $urandom_range(1, NS - 1);
                1: row.nsamp = $urandom_range(NS + 1, NS + 20);
                2: row.chan = 3'($urandom_range(6, 7));
                default: ;
            endcase
            run_cycle(row);
            rnd_beats = rnd_beats + row.nsamp;
        end

        in_valid = 1'b0;
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (200) @(negedge clk);
        $display("%0d input beats in %0d cycles; %0d result beats, %0d skipped",
                 beats_sent, cycles_analyzed, results_seen, skips_seen);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
